/* hdl/vci_pkg.sv */
// ----------------------------------------------------------------------------
// vci_pkg
// shared widths, sequencer codes and mode codes for the volume curve
// interpolator
// ----------------------------------------------------------------------------
package vci_pkg;

  localparam int unsigned MaxPointsDef = 8;

  localparam int unsigned LevelW = 16;  // user level, dB Q8.8, dB tenths
  localparam int unsigned NormW  = 17;  // normalised level, Q1.16
  localparam int unsigned CountW = 4;   // point count registers
  localparam int unsigned KeyW   = 25;  // curve key and search input
  localparam int unsigned ValW   = 18;  // curve value
  localparam int unsigned MulW   = 27;  // shared multiplier operands
  localparam int unsigned NumW   = 50;  // interpolation numerator
  localparam int unsigned DenW   = 35;  // interpolation denominator

  typedef enum logic [2:0] {
    MODE_LOAD_USER = 3'd0,
    MODE_LOAD_DB   = 3'd1,
    MODE_FORWARD   = 3'd2,
    MODE_REVERSE   = 3'd3,
    MODE_CLAMP     = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    PASS_FWD_USER,
    PASS_FWD_DB,
    PASS_REV_DB,
    PASS_REV_USER,
    PASS_CLAMP_LO,
    PASS_CLAMP_HI
  } pass_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WAIT,
    S_EVAL,
    S_MUL1,
    S_MUL2,
    S_DIV,
    S_DIVW
  } state_e;

endpackage

/* hdl/vci_ram.sv */
// ----------------------------------------------------------------------------
// vci_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module vci_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hdl/vci_div.sv */
// ----------------------------------------------------------------------------
// vci_div
// bit-serial restoring divider giving num/den rounded half away from zero
// ----------------------------------------------------------------------------
module vci_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [vci_pkg::NumW-1:0]   num_i,
  input  logic        [vci_pkg::DenW-1:0]   den_i,
  output logic                              done_o,
  output logic signed [vci_pkg::NumW-1:0]   quot_o
);
  import vci_pkg::*;

  localparam int unsigned NW = NumW + 1;   // dividend 2|num| + den
  localparam int unsigned DW = DenW + 1;   // divisor 2 den
  localparam int unsigned RW = DW + 1;
  localparam int unsigned CntW = $clog2(NW + 1);

  logic [NW-1:0]   dvd_q, quo_q;
  logic [DW-1:0]   dvs_q;
  logic [RW-1:0]   rem_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, neg_q, done_q;

  logic [NumW-1:0] mag;
  logic [RW-1:0]   rem_sh;
  logic            fits;

  assign mag    = num_i[NumW-1] ? NumW'(-num_i) : NumW'(num_i);
  assign rem_sh = {rem_q[RW-2:0], dvd_q[NW-1]};
  assign fits   = rem_sh >= RW'(dvs_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {mag, 1'b0} + NW'(den_i);
      dvs_q <= {den_i, 1'b0};
      rem_q <= '0;
      quo_q <= '0;
      neg_q <= num_i[NumW-1];
    end else if (busy_q) begin
      dvd_q <= {dvd_q[NW-2:0], 1'b0};
      rem_q <= fits ? rem_sh - RW'(dvs_q) : rem_sh;
      quo_q <= {quo_q[NW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -NumW'(quo_q) : NumW'(quo_q);

endmodule

/* hdl/volume_curve_interpolator.sv */
// ----------------------------------------------------------------------------
// volume_curve_interpolator
// two breakpoint curves (user volume to normalised level, normalised level to
// dB) with forward, reverse and clamp lookups using linear interpolation
// ----------------------------------------------------------------------------
// A beat is taken when start_i is high and busy_o is low. Every beat gives
// exactly one result beat, shown for one cycle with done_o high; the receiver
// cannot stall it, so it must capture result_value_o and status_o then.
// Point loads and unused modes raise done_o in the cycle after their start
// beat. Lookups walk each curve one point at a time through a single read
// port, use one shared multiplier for the two products of an interpolation
// and a bit-serial divider for each rounding. A pass that ends on a curve
// point skips the multiply states and, except for the dB pass of a forward
// lookup, the divider as well. A clamp reads only the first and last user
// curve points. The user must write the count registers only while idle;
// the block itself does not enforce it.
module volume_curve_interpolator #(
  parameter int unsigned MaxPoints = vci_pkg::MaxPointsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [2:0]                          mode_i,
  input  logic [2:0]                          point_index_i,
  input  logic signed [vci_pkg::LevelW-1:0]   user_level_i,
  input  logic        [vci_pkg::NormW-1:0]    norm_level_i,
  input  logic signed [vci_pkg::LevelW-1:0]   db_level_i,
  input  logic signed [vci_pkg::LevelW-1:0]   db_tenths_i,
  output logic                                done_o,
  output logic signed [vci_pkg::LevelW-1:0]   result_value_o,
  output logic                                status_o,
  input  logic                                cfg_we_i,
  input  logic                                cfg_index_i,
  input  logic [vci_pkg::CountW-1:0]          cfg_data_i
);
  import vci_pkg::*;

  localparam int unsigned AW = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int unsigned CW = $clog2(MaxPoints + 1);
  localparam int unsigned UW = LevelW + NormW;  // user ram word {key, norm}
  localparam int unsigned DBW = NormW + LevelW; // db ram word {norm, value}

  // configuration
  logic [CountW-1:0] user_cnt_q, db_cnt_q;
  logic [CW-1:0]     nu, nd, n_cur;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      user_cnt_q <= '0;
      db_cnt_q   <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == 1'b0) begin
        user_cnt_q <= cfg_data_i;
      end else begin
        db_cnt_q <= cfg_data_i;
      end
    end
  end

  // counts above the storage depth act as a full curve
  assign nu = (int'(user_cnt_q) > int'(MaxPoints)) ? CW'(MaxPoints) : CW'(user_cnt_q);
  assign nd = (int'(db_cnt_q) > int'(MaxPoints)) ? CW'(MaxPoints) : CW'(db_cnt_q);

  // sequencer registers
  state_e state_q, state_d;
  pass_e  pass_q, pass_d;
  logic [AW-1:0]              idx_q, idx_d;
  logic signed [KeyW-1:0]     x_q, x_d, pk_q, pk_d;
  logic signed [ValW-1:0]     pv_q, pv_d;
  logic signed [NumW-1:0]     num_q, num_d;
  logic [DenW-1:0]            den_q, den_d;
  logic                       done_q, done_d, status_q, status_d;
  logic signed [LevelW-1:0]   res_q, res_d;

  // curve storage
  logic           accept, load_ok, we_user, we_db;
  logic [UW-1:0]  user_rdata;
  logic [DBW-1:0] db_rdata;

  assign accept  = start_i && (state_q == S_IDLE);
  assign load_ok = int'(point_index_i) < int'(MaxPoints);
  assign we_user = accept && (mode_i == MODE_LOAD_USER) && load_ok;
  assign we_db   = accept && (mode_i == MODE_LOAD_DB) && load_ok;

  vci_ram #(.Width(UW), .Depth(MaxPoints), .AddrW(AW)) u_user_ram (
    .clk_i   (clk_i),
    .we_i    (we_user),
    .waddr_i (AW'(point_index_i)),
    .wdata_i ({user_level_i, norm_level_i}),
    .raddr_i (idx_q),
    .rdata_o (user_rdata)
  );

  vci_ram #(.Width(DBW), .Depth(MaxPoints), .AddrW(AW)) u_db_ram (
    .clk_i   (clk_i),
    .we_i    (we_db),
    .waddr_i (AW'(point_index_i)),
    .wdata_i ({norm_level_i, db_level_i}),
    .raddr_i (idx_q),
    .rdata_o (db_rdata)
  );

  // key and value of the point being read, as seen by the current pass
  logic signed [LevelW-1:0] ukey, dval;
  logic        [NormW-1:0]  unorm, dnorm;
  logic signed [KeyW-1:0]   rk, dval10;
  logic signed [ValW-1:0]   rv;

  assign ukey   = user_rdata[UW-1:NormW];
  assign unorm  = user_rdata[NormW-1:0];
  assign dnorm  = db_rdata[DBW-1:LevelW];
  assign dval   = db_rdata[LevelW-1:0];
  assign dval10 = (KeyW'(dval) <<< 3) + (KeyW'(dval) <<< 1);

  always_comb begin
    unique case (pass_q)
      PASS_FWD_DB: begin
        rk = KeyW'(signed'({1'b0, dnorm}));
        rv = ValW'(dval);
      end
      PASS_REV_DB: begin
        rk = dval10;
        rv = ValW'(signed'({1'b0, dnorm}));
      end
      PASS_REV_USER: begin
        rk = KeyW'(signed'({1'b0, unorm}));
        rv = ValW'(ukey);
      end
      default: begin  // user curve forward and clamp passes
        rk = KeyW'(ukey);
        rv = ValW'(signed'({1'b0, unorm}));
      end
    endcase
  end

  // shared multiplier: pv*d, then (v - pv)*(x - pk)
  logic signed [MulW-1:0]     mul_a, mul_b;
  logic signed [2*MulW-1:0]   mul_p;

  always_comb begin
    if (state_q == S_MUL1) begin
      mul_a = MulW'(pv_q);
      mul_b = MulW'(signed'({1'b0, den_q[KeyW:0]}));
    end else begin
      mul_a = MulW'(rv) - MulW'(pv_q);
      mul_b = MulW'(x_q) - MulW'(pk_q);
    end
  end
  assign mul_p = mul_a * mul_b;

  // rounding divider; the dB curve result is scaled by 10/256 on the way in
  logic                   div_start, div_done, shortcut, post;
  logic signed [NumW-1:0] div_num, div_q, q_sel;
  logic [DenW-1:0]        div_den;

  assign div_num  = (pass_q == PASS_FWD_DB) ? (num_q <<< 3) + (num_q <<< 1) : num_q;
  assign div_den  = (pass_q == PASS_FWD_DB) ? (den_q << 8) : den_q;
  assign shortcut = (pass_q != PASS_FWD_DB) && (den_q == DenW'(1));

  vci_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_q)
  );

  assign q_sel = (state_q == S_DIV) ? num_q : div_q;
  assign post  = ((state_q == S_DIV) && shortcut) || ((state_q == S_DIVW) && div_done);

  // helpers for the walk
  logic                   first_pt, last_pt;
  logic signed [KeyW:0]   seg_d;
  logic signed [LevelW-1:0] sat_res;

  assign first_pt = (idx_q == '0);
  assign last_pt  = ((CW'(idx_q) + CW'(1)) == n_cur);
  assign seg_d    = (KeyW+1)'(rk) - (KeyW+1)'(pk_q);
  assign n_cur    = ((pass_q == PASS_FWD_DB) || (pass_q == PASS_REV_DB)) ? nd : nu;

  always_comb begin
    if (q_sel > NumW'(32767)) begin
      sat_res = 16'sh7fff;
    end else if (q_sel < -NumW'(32768)) begin
      sat_res = -16'sh8000;
    end else begin
      sat_res = LevelW'(q_sel);
    end
  end

  always_comb begin
    state_d   = state_q;
    pass_d    = pass_q;
    idx_d     = idx_q;
    x_d       = x_q;
    pk_d      = pk_q;
    pv_d      = pv_q;
    num_d     = num_q;
    den_d     = den_q;
    done_d    = 1'b0;
    res_d     = res_q;
    status_d  = status_q;
    div_start = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          idx_d    = '0;
          status_d = 1'b0;
          res_d    = '0;
          priority case (mode_i)
            MODE_FORWARD, MODE_REVERSE: begin
              if ((nu == '0) || (nd == '0)) begin
                done_d   = 1'b1;
                status_d = 1'b1;
                res_d    = (mode_i == MODE_FORWARD) ? user_level_i : db_tenths_i;
              end else if (mode_i == MODE_FORWARD) begin
                pass_d  = PASS_FWD_USER;
                x_d     = KeyW'(user_level_i);
                state_d = S_WAIT;
              end else begin
                pass_d  = PASS_REV_DB;
                x_d     = KeyW'(db_tenths_i) <<< 8;
                state_d = S_WAIT;
              end
            end
            MODE_CLAMP: begin
              if (nu == '0) begin
                done_d   = 1'b1;
                status_d = 1'b1;
                res_d    = user_level_i;
              end else begin
                pass_d  = PASS_CLAMP_LO;
                x_d     = KeyW'(user_level_i);
                state_d = S_WAIT;
              end
            end
            default: begin  // loads and unused modes answer zero at once
              done_d = 1'b1;
            end
          endcase
        end
      end

      S_WAIT: begin
        state_d = S_EVAL;
      end

      S_EVAL: begin
        priority if (pass_q == PASS_CLAMP_LO) begin
          num_d   = (x_q < rk) ? NumW'(rk) : NumW'(x_q);
          idx_d   = AW'(nu - CW'(1));
          pass_d  = PASS_CLAMP_HI;
          state_d = S_WAIT;
        end else if (pass_q == PASS_CLAMP_HI) begin
          res_d   = (num_q > NumW'(rk)) ? LevelW'(rk) : LevelW'(num_q);
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (first_pt) begin
          pk_d = rk;
          pv_d = rv;
          if ((x_q <= rk) || (n_cur == CW'(1))) begin
            num_d   = NumW'(rv);
            den_d   = DenW'(1);
            state_d = S_DIV;
          end else begin
            idx_d   = idx_q + AW'(1);
            state_d = S_WAIT;
          end
        end else if (rk > x_q) begin
          // segment found: keep rv on the read port for the second product
          den_d   = DenW'(seg_d);
          state_d = S_MUL1;
        end else begin
          pk_d = rk;
          pv_d = rv;
          if ((rk == x_q) || last_pt) begin
            num_d   = NumW'(rv);
            den_d   = DenW'(1);
            state_d = S_DIV;
          end else begin
            idx_d   = idx_q + AW'(1);
            state_d = S_WAIT;
          end
        end
      end

      S_MUL1: begin
        num_d   = NumW'(mul_p);
        state_d = S_MUL2;
      end

      S_MUL2: begin
        num_d   = num_q + NumW'(mul_p);
        state_d = S_DIV;
      end

      S_DIV: begin
        if (!shortcut) begin
          div_start = 1'b1;
          state_d   = S_DIVW;
        end
      end

      S_DIVW: begin
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // rounded quotient feeds the next curve or becomes the result
    if (post) begin
      idx_d = '0;
      priority if (pass_q == PASS_FWD_USER) begin
        x_d     = KeyW'(q_sel);
        pass_d  = PASS_FWD_DB;
        state_d = S_WAIT;
      end else if (pass_q == PASS_REV_DB) begin
        x_d     = KeyW'(q_sel);
        pass_d  = PASS_REV_USER;
        state_d = S_WAIT;
      end else begin
        res_d   = sat_res;
        done_d  = 1'b1;
        state_d = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pass_q   <= PASS_FWD_USER;
      idx_q    <= '0;
      done_q   <= 1'b0;
      status_q <= 1'b0;
      res_q    <= '0;
    end else begin
      state_q  <= state_d;
      pass_q   <= pass_d;
      idx_q    <= idx_d;
      done_q   <= done_d;
      status_q <= status_d;
      res_q    <= res_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    pk_q  <= pk_d;
    pv_q  <= pv_d;
    num_q <= num_d;
    den_q <= den_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign result_value_o = res_q;
  assign status_o       = status_q;

endmodule

/* bench/volume_curve_interpolator_tb.sv */
// ----------------------------------------------------------------------------
// volume_curve_interpolator_tb
// self-checking bench: loads both breakpoint curves, steps the point counts
// through empty, short, full and oversized settings, and runs forward,
// reverse and clamp lookups against a cycle-free predictor of the curves
// ----------------------------------------------------------------------------
module volume_curve_interpolator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vci_pkg::*;

  localparam int Pts = 8;
  // count register indexes
  localparam bit CfgUserPoints = 1'b0;
  localparam bit CfgDbPoints   = 1'b1;

  typedef struct {
    logic        [2:0]  mode;
    logic        [2:0]  idx;
    logic signed [15:0] user_lvl;
    logic        [16:0] norm_lvl;
    logic signed [15:0] db_lvl;
    logic signed [15:0] tenths;
  } beat_t;

  typedef struct {
    logic signed [15:0] value;
    logic               status;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [2:0] mode_i = '0;
  logic [2:0] point_index_i = '0;
  logic signed [15:0] user_level_i = '0;
  logic [16:0] norm_level_i = '0;
  logic signed [15:0] db_level_i = '0;
  logic signed [15:0] db_tenths_i = '0;
  logic done_o;
  logic signed [15:0] result_value_o;
  logic status_o;
  logic cfg_we_i = 1'b0;
  logic cfg_index_i = 1'b0;
  logic [3:0] cfg_data_i = '0;

  volume_curve_interpolator u_top (
    .clk_i, .rst_ni, .start_i, .busy_o, .mode_i, .point_index_i,
    .user_level_i, .norm_level_i, .db_level_i, .db_tenths_i,
    .done_o, .result_value_o, .status_o, .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // beats waiting to be driven, and answers waiting for done_o
  beat_t   pending_beats[$];
  answer_t due_answers[$];

  // predictor copy of the block's state
  logic [3:0] user_cnt, db_cnt;
  longint user_keys[Pts], user_norms[Pts], db_norms[Pts], db_vals[Pts];
  // what the stimulus generator believes is loaded (runs ahead of the block)
  longint gen_keys[Pts], gen_dbv[Pts];

  int mismatches = 0;
  int n_fwd = 0, n_rev = 0, n_clamp = 0, n_load = 0, n_empty = 0;
  bit no_gaps = 1'b0;

  // ---------------------------------------------------------------- predictor
  // walk a curve of n points; result is num/den with den > 0
  function automatic void curve_walk(int n, longint k[Pts], longint v[Pts],
                                     longint x, output longint num,
                                     output longint den);
    longint pk, pv;
    pk = k[0];
    pv = v[0];
    den = 1;
    num = pv;
    if (x <= pk) return;
    for (int i = 1; i < n; i++) begin
      if (k[i] > x) begin
        // interpolate from the last point passed
        den = k[i] - pk;
        num = pv * den + (v[i] - pv) * (x - pk);
        return;
      end
      pk = k[i];
      pv = v[i];
      if (pk == x) break;
    end
    num = pv;
  endfunction

  function automatic longint round_half_away(longint num, longint den);
    if (num >= 0) return (2 * num + den) / (2 * den);
    return -((-2 * num + den) / (2 * den));
  endfunction

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int eff_count(logic [3:0] c);
    return (c > Pts) ? Pts : int'(c);
  endfunction

  // applies one accepted beat to the predictor state, returns its answer
  function automatic answer_t predict_lookup(beat_t b);
    answer_t a;
    int nu, nd;
    longint num, den, norm, lo, hi, r;
    longint scaled[Pts];
    nu = eff_count(user_cnt);
    nd = eff_count(db_cnt);
    a.value = '0;
    a.status = 1'b0;
    case (b.mode)
      MODE_LOAD_USER: begin
        user_keys[b.idx] = b.user_lvl;
        user_norms[b.idx] = b.norm_lvl;
      end
      MODE_LOAD_DB: begin
        db_norms[b.idx] = b.norm_lvl;
        db_vals[b.idx] = b.db_lvl;
      end
      MODE_FORWARD: begin
        if (nu == 0 || nd == 0) begin
          a.value = b.user_lvl;
          a.status = 1'b1;
        end else begin
          curve_walk(nu, user_keys, user_norms, b.user_lvl, num, den);
          norm = round_half_away(num, den);
          curve_walk(nd, db_norms, db_vals, norm, num, den);
          a.value = 16'(sat16(round_half_away(num * 10, den * 256)));
        end
      end
      MODE_REVERSE: begin
        if (nu == 0 || nd == 0) begin
          a.value = b.tenths;
          a.status = 1'b1;
        end else begin
          // compare in tenths scaled by 256 so the dB keys stay exact
          foreach (scaled[i]) scaled[i] = db_vals[i] * 10;
          curve_walk(nd, scaled, db_norms, longint'(b.tenths) * 256, num, den);
          norm = round_half_away(num, den);
          curve_walk(nu, user_norms, user_keys, norm, num, den);
          a.value = 16'(sat16(round_half_away(num, den)));
        end
      end
      MODE_CLAMP: begin
        if (nu == 0) begin
          a.value = b.user_lvl;
          a.status = 1'b1;
        end else begin
          lo = user_keys[0];
          hi = user_keys[nu - 1];
          r = (b.user_lvl < lo) ? lo : longint'(b.user_lvl);
          if (r > hi) r = hi;
          a.value = 16'(r);
        end
      end
      default: ;  // unused modes: no change, zero answer
    endcase
    return a;
  endfunction

  // ------------------------------------------------------------------ driver
  bit took = 1'b0;
  int gap_left = 0;

  always @(negedge clk_i) begin
    if (rst_ni && (!start_i || took)) begin
      if (gap_left > 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        beat_t b;
        b = pending_beats.pop_front();
        mode_i <= b.mode;
        point_index_i <= b.idx;
        user_level_i <= b.user_lvl;
        norm_level_i <= b.norm_lvl;
        db_level_i <= b.db_lvl;
        db_tenths_i <= b.tenths;
        start_i <= 1'b1;
        gap_left = no_gaps ? 0 : $urandom_range(0, 5);
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // ----------------------------------------------------------------- monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      // result beat: compare against the oldest outstanding answer
      if (done_o) begin
        if (due_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result beat with nothing outstanding: value %0d status %0d",
                     $realtime, result_value_o, status_o);
        end else begin
          answer_t e;
          e = due_answers.pop_front();
          if (result_value_o !== e.value || status_o !== e.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch value exp %0d got %0d, status exp %0d got %0d",
                       $realtime, e.value, result_value_o, e.status, status_o);
          end
        end
      end
      // input beat taken at this edge
      took = start_i && !busy_o;
      if (took) begin
        beat_t b;
        answer_t a;
        b = '{mode_i, point_index_i, user_level_i, norm_level_i, db_level_i,
              db_tenths_i};
        a = predict_lookup(b);
        if (a.status) n_empty++;
        case (mode_i)
          MODE_FORWARD: n_fwd++;
          MODE_REVERSE: n_rev++;
          MODE_CLAMP:   n_clamp++;
          default:      n_load++;
        endcase
        due_answers = {due_answers, a};
      end
    end
  end

  // --------------------------------------------------------------- stimulus
  function automatic logic signed [15:0] rnd16();
    return 16'($urandom);
  endfunction

  task automatic queue_beat(logic [2:0] m, logic [2:0] i, logic signed [15:0] ul,
                            logic [16:0] nl, logic signed [15:0] dl,
                            logic signed [15:0] dt);
    beat_t b;
    b = '{m, i, ul, nl, dl, dt};
    pending_beats = {pending_beats, b};
    if (m == MODE_LOAD_USER) gen_keys[i] = ul;
    if (m == MODE_LOAD_DB) gen_dbv[i] = dl;
  endtask

  // style: 0 ascending, 1 full-scale extremes at the ends, 2 unordered
  task automatic queue_curves(int style);
    longint k, n, dn, dv;
    k = -32768 + $urandom_range(0, 30000);
    n = $urandom_range(0, 8000);
    dn = $urandom_range(0, 8000);
    dv = -30000 + $urandom_range(0, 20000);
    for (int i = 0; i < Pts; i++) begin
      if (style == 2) begin
        queue_beat(MODE_LOAD_USER, 3'(i), rnd16(), 17'($urandom_range(0, 65536)),
                   rnd16(), rnd16());
        queue_beat(MODE_LOAD_DB, 3'(i), rnd16(), 17'($urandom_range(0, 65536)),
                   rnd16(), rnd16());
      end else begin
        if (style == 1 && i == 0) begin
          k = -32768; n = 0; dn = 0; dv = -32768;
        end else if (style == 1 && i == Pts - 1) begin
          k = 32767; n = 65536; dn = 65536; dv = 32767;
        end
        queue_beat(MODE_LOAD_USER, 3'(i), 16'(k), 17'(n), rnd16(), rnd16());
        queue_beat(MODE_LOAD_DB, 3'(i), rnd16(), 17'(dn), 16'(dv), rnd16());
        // repeated keys now and then
        k += ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 9000);
        n += $urandom_range(0, 12000);
        dn += $urandom_range(0, 12000);
        dv += $urandom_range(0, 9000);
        if (k > 32767) k = 32767;
        if (n > 65536) n = 65536;
        if (dn > 65536) dn = 65536;
        if (dv > 32767) dv = 32767;
      end
    end
  endtask

  task automatic queue_random_beat();
    int pick, p;
    logic signed [15:0] ul, dt;
    p = $urandom_range(0, Pts - 1);
    pick = $urandom_range(0, 3);
    case (pick)
      0: ul = rnd16();
      1: ul = 16'(gen_keys[p]);
      default: ul = 16'(gen_keys[p] + $urandom_range(0, 400) - 200);
    endcase
    pick = $urandom_range(0, 3);
    case (pick)
      0: dt = rnd16();
      1: dt = 16'((gen_dbv[p] * 10) / 256);
      default: dt = 16'((gen_dbv[p] * 10) / 256 + $urandom_range(0, 40) - 20);
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 38)
      queue_beat(MODE_FORWARD, 3'($urandom), ul, 17'($urandom_range(0, 65536)),
                 rnd16(), dt);
    else if (pick < 76)
      queue_beat(MODE_REVERSE, 3'($urandom), ul, 17'($urandom_range(0, 65536)),
                 rnd16(), dt);
    else if (pick < 92)
      queue_beat(MODE_CLAMP, 3'($urandom), ul, 17'($urandom_range(0, 65536)),
                 rnd16(), dt);
    else if (pick < 96)
      queue_beat(3'($urandom_range(int'(MODE_CLAMP) + 1, 7)), 3'($urandom), ul,
                 17'($urandom_range(0, 65536)), rnd16(), dt);
    else
      // a stray point reload, ascending order not guaranteed
      queue_beat(($urandom_range(0, 1) == 0) ? MODE_LOAD_USER : MODE_LOAD_DB,
                 3'($urandom), ul, 17'($urandom_range(0, 65536)), rnd16(), dt);
  endtask

  // wait until every beat is sent and answered, then let the block settle
  task automatic drain();
    while (pending_beats.size() > 0 || due_answers.size() > 0 || start_i)
      @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_count(bit idx, logic [3:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    user_cnt = (idx == CfgUserPoints) ? val : user_cnt;
    db_cnt = (idx == CfgDbPoints) ? val : db_cnt;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [3:0] counts[7];
    counts = '{4'd0, 4'd1, 4'd2, 4'd5, 4'd8, 4'd15, 4'd9};
    user_cnt = '0;
    db_cnt = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty curves: every lookup passes through with status set
    queue_beat(MODE_FORWARD, '0, 16'sh7fff, '0, '0, '0);
    queue_beat(MODE_FORWARD, '1, 16'sh8000, '1, '1, '1);
    queue_beat(MODE_REVERSE, '0, '0, '0, '0, 16'sh8000);
    queue_beat(MODE_REVERSE, '0, '0, '0, '0, 16'sh7fff);
    queue_beat(MODE_CLAMP, '0, 16'sh8000, '0, '0, '0);
    queue_beat(3'(int'(MODE_CLAMP) + 1), '1, '1, '1, '1, '1);
    queue_beat('1, '0, '0, '0, '0, '0);
    // full-scale curves with the extreme keys, values and levels at the ends
    queue_curves(1);
    drain();
    write_count(CfgUserPoints, 4'd8);
    write_count(CfgDbPoints, 4'd8);
    // below first point, above last, exact end hits
    queue_beat(MODE_FORWARD, '0, 16'sh8000, '0, '0, '0);
    queue_beat(MODE_FORWARD, '0, 16'sh7fff, '0, '0, '0);
    queue_beat(MODE_REVERSE, '0, '0, '0, '0, 16'sh8000);
    queue_beat(MODE_REVERSE, '0, '0, '0, '0, 16'sh7fff);
    queue_beat(MODE_CLAMP, '0, 16'sh8000, '0, '0, '0);
    queue_beat(MODE_CLAMP, '0, 16'sh7fff, '0, '0, '0);
    drain();

    // random phases; the sender fully pauses at each phase boundary
    for (int ph = 0; ph < 14; ph++) begin
      no_gaps = (ph % 4 == 1);
      queue_curves((ph % 5 == 4) ? 2 : ((ph % 7 == 3) ? 1 : 0));
      drain();
      write_count(CfgUserPoints, (ph < 7) ? counts[ph] : 4'($urandom_range(0, 15)));
      write_count(CfgDbPoints, (ph < 7) ? counts[6 - ph] : 4'($urandom_range(0, 15)));
      // mostly full curves after the first sweep
      if (ph >= 9) begin
        write_count(CfgUserPoints, 4'd8);
        write_count(CfgDbPoints, 4'd8);
      end
      for (int i = 0; i < 122; i++) queue_random_beat();
      drain();
    end

    repeat (200) @(posedge clk_i);
    $display("covered %0d forward, %0d reverse, %0d clamp, %0d load/other beats",
             n_fwd, n_rev, n_clamp, n_load);
    $display("%0d answers passed through on an empty curve, %0d mismatches",
             n_empty, mismatches);
    if (mismatches == 0 && due_answers.size() == 0) begin
      $display("volume_curve_interpolator_tb: clean");
    end else begin
      $display("volume_curve_interpolator_tb: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(30_000_000);
    $display("volume_curve_interpolator_tb: errors");
    $finish;
  end

endmodule
